// ----- src/uart_transmitter_defines.svh -----
// Assertion macros used by the transmitter engine.
`ifndef UART_TRANSMITTER_DEFINES_SVH
`define UART_TRANSMITTER_DEFINES_SVH

// Checks that a condition implies another in the same cycle.
`define UTX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies another in the following cycle.
`define UTX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/utx_pkg.sv -----
// Shared types, constants and helper functions of the UART transmitter.
package utx_pkg;

    localparam int MAX_DATA_BITS = 8;
    localparam int MIN_DATA_BITS = 5;
    localparam int PERIOD_WIDTH  = 16;
    localparam int BYTE_W        = 8;
    localparam int TICK_W        = PERIOD_WIDTH + 1;
    localparam int WIDTH_W       = 4;
    localparam int BITS_LEFT_W   = $clog2(MAX_DATA_BITS + 1);
    localparam int ADDR_W        = 5;
    localparam int PDATA_W       = 32;

    // Register indexes.
    localparam logic [2:0] REG_BIT_PERIOD  = 3'd0;
    localparam logic [2:0] REG_DATA_BITS   = 3'd1;
    localparam logic [2:0] REG_PARITY_MODE = 3'd2;
    localparam logic [2:0] REG_STOP_MODE   = 3'd3;
    localparam logic [2:0] REG_MSB_FIRST   = 3'd4;

    // Parity codes.
    localparam logic [2:0] PAR_NONE  = 3'd0;
    localparam logic [2:0] PAR_EVEN  = 3'd1;
    localparam logic [2:0] PAR_ODD   = 3'd2;
    localparam logic [2:0] PAR_MARK  = 3'd3;
    localparam logic [2:0] PAR_SPACE = 3'd4;

    // Stop codes.
    localparam logic [1:0] STOP_ONE      = 2'd0;
    localparam logic [1:0] STOP_ONE_HALF = 2'd1;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] bit_period;
        logic [WIDTH_W-1:0]      data_bits;
        logic [2:0]              parity_mode;
        logic [1:0]              stop_mode;
        logic                    msb_first;
    } cfg_t;

    typedef struct packed {
        logic              offer;
        logic [BYTE_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy;
        logic accepted;
    } result_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        r = w;
        if (w < WIDTH_W'(MIN_DATA_BITS))
        begin
            r = WIDTH_W'(MIN_DATA_BITS);
        end
        else if (w > WIDTH_W'(MAX_DATA_BITS))
        begin
            r = WIDTH_W'(MAX_DATA_BITS);
        end
        return r;
    endfunction

    function automatic logic parity_enabled(input logic [2:0] mode);
        return (mode == PAR_EVEN) || (mode == PAR_ODD) || (mode == PAR_MARK)
            || (mode == PAR_SPACE);
    endfunction

endpackage

// ----- src/uart_transmitter.sv -----
// Top level of the UART transmitter.
//
// Every word pushed on the input queue is one tick of bit timing: command 1
// offers tx_byte, command 0 is a plain tick. Every tick yields exactly one
// result word on the output queue: line_level (serial level in that tick),
// busy_res (frame on the line) and accepted (the offer was taken). An offer is
// taken only while the line is idle; the frame is a low start bit, the data bits,
// an optional parity bit and the stop time, each bit bit_period ticks (min 2).
// Throughput is one tick per clock cycle while the result queue has room. A push
// is registered in the input queue, then the sequencer writes the result queue.
// The sequencer step is a combinational compare of the 17-bit tick counter
// against the bit length. Both queues hold two words. When the receiver stops
// popping, the result queue fills, the sequencer stalls and then full rises; no
// tick is dropped and bit timing counts ticks, not cycles. Reset empties both
// queues, idles the line and loads the register defaults. The user must write
// the APB configuration only while no tick is in flight; this is not enforced.
module uart_transmitter
    import utx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [BYTE_W-1:0]  tx_byte,
    output logic               empty,
    input  logic               pop,
    output logic               line_level,
    output logic               busy_res,
    output logic               accepted,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t    cfg;
    logic    item_valid;
    item_t   item;
    logic    item_take;
    result_t head;

    utx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    utx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .tx_byte    (tx_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    utx_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .empty      (empty),
        .pop        (pop),
        .head       (head)
    );

    assign line_level = head.line_level;
    assign busy_res   = head.busy;
    assign accepted   = head.accepted;

endmodule

// ----- src/utx_regs.sv -----
// APB configuration registers of the UART transmitter.
module utx_regs
    import utx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_BIT_PERIOD:  cfg_next.bit_period  = pwdata[PERIOD_WIDTH-1:0];
                REG_DATA_BITS:   cfg_next.data_bits   = pwdata[WIDTH_W-1:0];
                REG_PARITY_MODE: cfg_next.parity_mode = pwdata[2:0];
                REG_STOP_MODE:   cfg_next.stop_mode   = pwdata[1:0];
                REG_MSB_FIRST:   cfg_next.msb_first   = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_BIT_PERIOD:  prdata = PDATA_W'(cfg_reg.bit_period);
            REG_DATA_BITS:   prdata = PDATA_W'(cfg_reg.data_bits);
            REG_PARITY_MODE: prdata = PDATA_W'(cfg_reg.parity_mode);
            REG_STOP_MODE:   prdata = PDATA_W'(cfg_reg.stop_mode);
            REG_MSB_FIRST:   prdata = PDATA_W'(cfg_reg.msb_first);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period  <= PERIOD_WIDTH'(16);
            cfg_reg.data_bits   <= WIDTH_W'(MAX_DATA_BITS);
            cfg_reg.parity_mode <= PAR_NONE;
            cfg_reg.stop_mode   <= STOP_ONE;
            cfg_reg.msb_first   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/utx_front.sv -----
// Input side: takes tick words, classifies them and queues them for the engine.
module utx_front
    import utx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              command,
    input  logic [BYTE_W-1:0] tx_byte,
    output logic              item_valid,
    output item_t             item,
    input  logic              item_take
);

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       wr_en;
    logic       rd_en;
    item_t      in_item;

    assign full       = (cnt_reg == 2'd2);
    assign wr_en      = push && !full;
    assign item_valid = (cnt_reg != 2'd0);
    assign rd_en      = item_take && item_valid;
    assign item       = mem[rd_ptr_reg];

    // A tick word only matters as an offer when its command bit is set.
    assign in_item.offer = command;
    assign in_item.data  = tx_byte;

    assign wr_ptr_next = wr_en ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
    assign cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- src/utx_engine.sv -----
// Back end: frame sequencer with bit timer, and the result queue.
`include "uart_transmitter_defines.svh"

module utx_engine
    import utx_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_take,
    output logic    empty,
    input  logic    pop,
    output result_t head
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_PARITY = 3'd3;
    localparam logic [2:0] PH_STOP   = 3'd4;

    logic [2:0]               phase_reg;
    logic [2:0]               phase_next;
    logic [MAX_DATA_BITS-1:0] shift_reg;
    logic [MAX_DATA_BITS-1:0] shift_next;
    logic [BITS_LEFT_W-1:0]   bits_left_reg;
    logic [BITS_LEFT_W-1:0]   bits_left_next;
    logic [TICK_W-1:0]        tick_reg;
    logic [TICK_W-1:0]        tick_next;
    logic                     parity_reg;
    logic                     parity_next;

    logic [WIDTH_W-1:0]       width;
    logic [MAX_DATA_BITS-1:0] mask;
    logic [MAX_DATA_BITS-1:0] data_masked;
    logic [MAX_DATA_BITS-1:0] data_rev;
    logic [MAX_DATA_BITS-1:0] load_data;
    logic                     ones;
    logic                     load_parity;
    logic [PERIOD_WIDTH-1:0]  period;
    logic [TICK_W-1:0]        stop_len;
    logic                     par_on;

    logic [2:0]               ph;
    logic [MAX_DATA_BITS-1:0] sh;
    logic [BITS_LEFT_W-1:0]   bl;
    logic [TICK_W-1:0]        tc;
    logic                     pb;
    logic [TICK_W-1:0]        len;
    result_t                  res;

    result_t    out_mem [2];
    logic       out_wr_ptr_reg;
    logic       out_rd_ptr_reg;
    logic [1:0] out_cnt_reg;
    logic [1:0] out_cnt_next;
    logic       out_rd_en;

    // Frame load values, taken when an offer meets an idle line.
    assign width = clamp_width(cfg.data_bits);

    always_comb
    begin
        for (int k = 0; k < MAX_DATA_BITS; k++)
        begin
            mask[k]     = (WIDTH_W'(k) < width);
            data_rev[k] = data_masked[MAX_DATA_BITS-1-k];
        end
    end

    assign data_masked = item.data[MAX_DATA_BITS-1:0] & mask;
    assign ones        = ^data_masked;
    // Reversing the full vector leaves the frame at the top; shift it back down.
    assign load_data   = cfg.msb_first
                       ? (data_rev >> (WIDTH_W'(MAX_DATA_BITS) - width)) : data_masked;

    always_comb
    begin
        case (cfg.parity_mode)
            PAR_EVEN: load_parity = ones;
            PAR_ODD:  load_parity = !ones;
            PAR_MARK: load_parity = 1'b1;
            default:  load_parity = 1'b0;
        endcase
    end

    assign period = (cfg.bit_period < PERIOD_WIDTH'(2)) ? PERIOD_WIDTH'(2) : cfg.bit_period;
    assign par_on = parity_enabled(cfg.parity_mode);

    always_comb
    begin
        case (cfg.stop_mode)
            STOP_ONE:      stop_len = {1'b0, period};
            STOP_ONE_HALF: stop_len = {1'b0, period} + {2'b00, period[PERIOD_WIDTH-1:1]};
            default:       stop_len = {period, 1'b0};
        endcase
    end

    // One tick of the sequencer.
    always_comb
    begin
        ph  = phase_reg;
        sh  = shift_reg;
        bl  = bits_left_reg;
        tc  = tick_reg;
        pb  = parity_reg;
        len = {1'b0, period};
        res.accepted = 1'b0;
        if (item.offer && (phase_reg == PH_IDLE))
        begin
            res.accepted = 1'b1;
            ph = PH_START;
            sh = load_data;
            bl = BITS_LEFT_W'(width);
            tc = '0;
            pb = load_parity;
        end

        case (ph)
            PH_START:  res.line_level = 1'b0;
            PH_DATA:   res.line_level = sh[0];
            PH_PARITY: res.line_level = pb;
            default:   res.line_level = 1'b1;
        endcase
        res.busy = (ph != PH_IDLE);

        if (ph == PH_STOP)
        begin
            len = stop_len;
        end
        if (ph != PH_IDLE)
        begin
            tc = tc + TICK_W'(1);
            if (tc >= len)
            begin
                tc = '0;
                case (ph)
                    PH_START:
                    begin
                        ph = (bl != '0) ? PH_DATA : (par_on ? PH_PARITY : PH_STOP);
                    end
                    PH_DATA:
                    begin
                        sh = sh >> 1;
                        bl = (bl != '0) ? bl - BITS_LEFT_W'(1) : bl;
                        if (bl == '0)
                        begin
                            ph = par_on ? PH_PARITY : PH_STOP;
                        end
                    end
                    PH_PARITY: ph = PH_STOP;
                    default:   ph = PH_IDLE;
                endcase
            end
        end
    end

    // A tick is processed only when its result has a slot to go to.
    assign out_rd_en = pop && (out_cnt_reg != 2'd0);
    assign item_take = item_valid && ((out_cnt_reg != 2'd2) || out_rd_en);
    assign empty     = (out_cnt_reg == 2'd0);
    assign head      = out_mem[out_rd_ptr_reg];

    assign phase_next     = item_take ? ph : phase_reg;
    assign shift_next     = item_take ? sh : shift_reg;
    assign bits_left_next = item_take ? bl : bits_left_reg;
    assign tick_next      = item_take ? tc : tick_reg;
    assign parity_next    = item_take ? pb : parity_reg;
    assign out_cnt_next   = out_cnt_reg + {1'b0, item_take} - {1'b0, out_rd_en};

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            out_mem[out_wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            shift_reg      <= '0;
            bits_left_reg  <= '0;
            tick_reg       <= '0;
            parity_reg     <= 1'b0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_cnt_reg    <= 2'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            bits_left_reg  <= bits_left_next;
            tick_reg       <= tick_next;
            parity_reg     <= parity_next;
            out_wr_ptr_reg <= item_take ? !out_wr_ptr_reg : out_wr_ptr_reg;
            out_rd_ptr_reg <= out_rd_en ? !out_rd_ptr_reg : out_rd_ptr_reg;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    `UTX_ASSERT_NOW(a_out_no_overflow, 1'b1, out_cnt_reg != 2'd3, "result queue overflow")
    `UTX_ASSERT_NOW(a_idle_timer_clear, phase_reg == PH_IDLE, tick_reg == '0, "timer runs while idle")
    `UTX_ASSERT_NOW(a_data_bits_left, phase_reg == PH_DATA, bits_left_reg != '0, "data phase with no bits")
    `UTX_ASSERT_NEXT(a_accept_starts, item_take && res.accepted, phase_reg != PH_IDLE, "accepted byte left line idle")

endmodule
